// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL. Synthesis builds define SYNTH to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define LUFNP_CHECK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lufnp check failed");
// The expression must never be true outside reset.
`define LUFNP_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("lufnp forbidden condition");
`else
`define LUFNP_CHECK(lbl, clk, rst, prop)
`define LUFNP_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ----- rtl/core/lufnp_pkg.sv -----
package lufnp_pkg;

  // Fixed field widths and number format.
  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 24;
  localparam int OP_W      = 2;
  localparam int IDX_W     = 4;
  localparam int SIZE_W    = 5;
  localparam int STAT_W    = 2;
  localparam int QUO_W     = DATA_W + FRAC_W;
  localparam int MAX_N_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_FACTOR = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_ZERO_PIVOT = 2'd1,
    STAT_SAT        = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_PIV_RD,
    ST_PIV_LAT,
    ST_DIV_RD,
    ST_DIV_LAT,
    ST_DIV_RUN,
    ST_L_RD,
    ST_L_LAT,
    ST_U_RD,
    ST_A_RD,
    ST_MUL,
    ST_RND,
    ST_WB
  } state_t;

  // Divider status and result towards the sequencer.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic              sat;
    logic [DATA_W-1:0] q;
  } div_res_t;

endpackage

// ----- rtl/core/lufnp_chan_if.sv -----
// Command channel: one word is one write, factorize or read request.
interface lufnp_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [lufnp_pkg::OP_W-1:0]    opcode;
  logic [lufnp_pkg::IDX_W-1:0]   row;
  logic [lufnp_pkg::IDX_W-1:0]   col;
  logic signed [lufnp_pkg::DATA_W-1:0] value;

  modport source (output valid, opcode, row, col, value, input ready);
  modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

// Response channel: one word per command.
interface lufnp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic signed [lufnp_pkg::DATA_W-1:0] data;
  logic [lufnp_pkg::STAT_W-1:0]  status;

  modport source (output valid, data, status, input ready);
  modport sink   (input valid, data, status, output ready);
endinterface

// ----- rtl/core/lufnp_ram.sv -----
// Simple dual-port RAM, one write and one registered read port.
module lufnp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/lufnp_div.sv -----
// Radix-2 restoring divider for the Q8.24 multiplier a / d.
// One quotient bit per cycle; the rounded, saturated result is shown on done.
module lufnp_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [lufnp_pkg::DATA_W-1:0] a,
  input  logic signed [lufnp_pkg::DATA_W-1:0] d,
  output lufnp_pkg::div_res_t                 res
);

  localparam int W  = lufnp_pkg::DATA_W;
  localparam int QW = lufnp_pkg::QUO_W;
  localparam int CW = $clog2(QW);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [QW-1:0] quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  den;
  logic          neg;

  logic [W:0]    rem_sh;
  logic          ge;
  logic [W-1:0]  amag;
  logic [W-1:0]  dmag;
  logic          rnd;
  logic [QW:0]   qr;

  // Magnitudes of the operands.
  assign amag = a[W-1] ? W'(-a) : W'(a);
  assign dmag = d[W-1] ? W'(-d) : W'(d);

  // One restoring step.
  assign rem_sh = {rem, quo[QW-1]};
  assign ge     = rem_sh >= {1'b0, den};

  // Control: a fixed number of steps, then one cycle with the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: numerator shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= {amag, {lufnp_pkg::FRAC_W{1'b0}}};
      rem <= '0;
      den <= dmag;
      neg <= a[W-1] ^ d[W-1];
    end else if (busy) begin
      quo <= {quo[QW-2:0], ge};
      rem <= ge ? W'(rem_sh - {1'b0, den}) : rem_sh[W-1:0];
    end
  end

  // Round half away from zero, then apply the sign and saturate.
  assign rnd = {rem, 1'b0} >= {1'b0, den};
  assign qr  = {1'b0, quo} + (QW+1)'(rnd);

  always_comb begin
    res.busy = busy;
    res.done = done;
    res.sat  = 1'b0;
    res.q    = '0;
    if (!neg) begin
      if (qr > (QW+1)'({1'b0, {(W-1){1'b1}}})) begin
        res.sat = 1'b1;
        res.q   = {1'b0, {(W-1){1'b1}}};
      end else begin
        res.q = qr[W-1:0];
      end
    end else begin
      if (qr > (QW+1)'({1'b1, {(W-1){1'b0}}})) begin
        res.sat = 1'b1;
        res.q   = {1'b1, {(W-1){1'b0}}};
      end else begin
        res.q = W'(-qr[W-1:0]);
      end
    end
  end

endmodule

// ----- rtl/core/lu_factorization_no_pivot.sv -----
// In-place LU factorization without pivoting over a Q8.24 matrix in one RAM.
// A write in range is stored directly; a read returns the registered RAM word. Factorize of
// order n checks each pivot, makes n*(n-1)/2 divisions on the bit-serial divider and then
// updates each trailing element of every row below the pivot.
// One command at a time; a new command is taken once the response slot is free.
// Synchronous reset clears control and status; the matrix RAM is not cleared.
`include "assert_macros.svh"

module lu_factorization_no_pivot #(
  parameter int MAX_N = lufnp_pkg::MAX_N_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lufnp_pkg::SIZE_W-1:0]      cfg_wdata,
  lufnp_cmd_if.sink                         cmd,
  lufnp_rsp_if.source                       rsp
);

  localparam int W     = lufnp_pkg::DATA_W;
  localparam int FW    = lufnp_pkg::FRAC_W;
  localparam int IW    = $clog2(MAX_N);
  localparam int NW    = IW + 1;
  localparam int DEPTH = MAX_N * MAX_N;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = 2 * W - FW + 1;

  lufnp_pkg::state_t state, state_next;

  // Configuration and status.
  logic [lufnp_pkg::SIZE_W-1:0] matrix_size;
  lufnp_pkg::status_t           last_status;
  logic [NW-1:0]                n_eff;
  logic [NW-1:0]                n_last;

  // Loop counters and operands.
  logic [IW-1:0]       i, r, c;
  logic signed [W-1:0] piv, l_reg, u_reg, a_reg;
  logic signed [2*W-1:0] prod;
  logic signed [MW-1:0]  prm;
  logic                sat;

  // Memory ports.
  logic          mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [W-1:0]  wdata, rdata;

  // Divider.
  logic                div_start;
  lufnp_pkg::div_res_t div_res;

  // Response register.
  logic               out_valid;
  logic [W-1:0]       out_data;
  lufnp_pkg::status_t out_status;
  logic               out_load;
  logic [W-1:0]       load_data;
  lufnp_pkg::status_t load_status;
  logic               fin;
  logic               cmd_fire;
  logic               cmd_inside;
  logic               rd_inside;
  logic [IW-1:0]      cmd_r, cmd_c;

  // Update arithmetic.
  logic [2*W-1:0]      pmag;
  logic [2*W-1:0]      psum;
  logic [MW-2:0]       mmag;
  logic signed [MW:0]  diff;
  logic signed [W-1:0] wb_val;
  logic                wb_sat;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] ar, input logic [IW-1:0] ac);
    addr_of = AW'(AW'(ar) * AW'(MAX_N) + AW'(ac));
  endfunction

  // Effective order, limited to 1..MAX_N.
  always_comb begin
    if (matrix_size == '0) begin
      n_eff = NW'(1);
    end else if (8'(matrix_size) > 8'(MAX_N)) begin
      n_eff = NW'(MAX_N);
    end else begin
      n_eff = NW'(matrix_size);
    end
  end
  assign n_last = n_eff - NW'(1);

  assign cmd.ready  = (state == lufnp_pkg::ST_IDLE) && (!out_valid || rsp.ready);
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign cmd_inside = (8'(cmd.row) < 8'(MAX_N)) && (8'(cmd.col) < 8'(MAX_N));
  assign cmd_r      = IW'(cmd.row);
  assign cmd_c      = IW'(cmd.col);

  // Rounded product and saturated difference for the trailing update.
  assign pmag = prod[2*W-1] ? (2*W)'(-prod) : (2*W)'(prod);
  assign psum = pmag + (2*W)'(64'd1 << (FW - 1));
  assign mmag = (MW-1)'(psum >> FW);
  assign diff = (MW+1)'(a_reg) - (MW+1)'(prm);

  always_comb begin
    wb_sat = 1'b0;
    wb_val = W'(diff);
    if (diff > (MW+1)'($signed({1'b0, {(W-1){1'b1}}}))) begin
      wb_sat = 1'b1;
      wb_val = {1'b0, {(W-1){1'b1}}};
    end else if (diff < (MW+1)'($signed({1'b1, {(W-1){1'b0}}}))) begin
      wb_sat = 1'b1;
      wb_val = {1'b1, {(W-1){1'b0}}};
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lufnp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory accesses and response loads.
  always_comb begin
    state_next  = state;
    mem_we      = 1'b0;
    waddr       = addr_of(cmd_r, cmd_c);
    wdata       = cmd.value;
    raddr       = addr_of(cmd_r, cmd_c);
    div_start   = 1'b0;
    out_load    = 1'b0;
    load_data   = '0;
    load_status = last_status;
    fin         = 1'b0;
    case (state)
      lufnp_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          case (lufnp_pkg::opcode_t'(cmd.opcode))
            lufnp_pkg::OP_WRITE: begin
              mem_we   = cmd_inside;
              out_load = 1'b1;
            end
            lufnp_pkg::OP_READ: begin
              state_next = lufnp_pkg::ST_RD_WAIT;
            end
            lufnp_pkg::OP_FACTOR: begin
              if (n_eff == NW'(1)) begin
                out_load    = 1'b1;
                fin         = 1'b1;
                load_status = lufnp_pkg::STAT_OK;
              end else begin
                state_next = lufnp_pkg::ST_PIV_RD;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      lufnp_pkg::ST_RD_WAIT: begin
        out_load   = 1'b1;
        load_data  = rd_inside ? rdata : '0;
        state_next = lufnp_pkg::ST_IDLE;
      end
      lufnp_pkg::ST_PIV_RD: begin
        raddr      = addr_of(i, i);
        state_next = lufnp_pkg::ST_PIV_LAT;
      end
      lufnp_pkg::ST_PIV_LAT: begin
        if (rdata == '0) begin
          out_load    = 1'b1;
          fin         = 1'b1;
          load_status = lufnp_pkg::STAT_ZERO_PIVOT;
          state_next  = lufnp_pkg::ST_IDLE;
        end else begin
          state_next = lufnp_pkg::ST_DIV_RD;
        end
      end
      lufnp_pkg::ST_DIV_RD: begin
        raddr      = addr_of(r, i);
        state_next = lufnp_pkg::ST_DIV_LAT;
      end
      lufnp_pkg::ST_DIV_LAT: begin
        div_start  = 1'b1;
        state_next = lufnp_pkg::ST_DIV_RUN;
      end
      lufnp_pkg::ST_DIV_RUN: begin
        if (div_res.done) begin
          mem_we = 1'b1;
          waddr  = addr_of(r, i);
          wdata  = div_res.q;
          state_next = (NW'(r) == n_last) ? lufnp_pkg::ST_L_RD : lufnp_pkg::ST_DIV_RD;
        end
      end
      lufnp_pkg::ST_L_RD: begin
        raddr      = addr_of(r, i);
        state_next = lufnp_pkg::ST_L_LAT;
      end
      lufnp_pkg::ST_L_LAT: begin
        state_next = lufnp_pkg::ST_U_RD;
      end
      lufnp_pkg::ST_U_RD: begin
        raddr      = addr_of(i, c);
        state_next = lufnp_pkg::ST_A_RD;
      end
      lufnp_pkg::ST_A_RD: begin
        raddr      = addr_of(r, c);
        state_next = lufnp_pkg::ST_MUL;
      end
      lufnp_pkg::ST_MUL: begin
        state_next = lufnp_pkg::ST_RND;
      end
      lufnp_pkg::ST_RND: begin
        state_next = lufnp_pkg::ST_WB;
      end
      lufnp_pkg::ST_WB: begin
        mem_we = 1'b1;
        waddr  = addr_of(r, c);
        wdata  = wb_val;
        if (NW'(c) != n_last) begin
          state_next = lufnp_pkg::ST_U_RD;
        end else if (NW'(r) != n_last) begin
          state_next = lufnp_pkg::ST_L_RD;
        end else if (NW'(i) + NW'(1) != n_last) begin
          state_next = lufnp_pkg::ST_PIV_RD;
        end else begin
          out_load    = 1'b1;
          fin         = 1'b1;
          load_status = (sat || wb_sat) ? lufnp_pkg::STAT_SAT : lufnp_pkg::STAT_OK;
          state_next  = lufnp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lufnp_pkg::ST_IDLE;
      end
    endcase
  end

  // Loop counters, operand registers and the saturation flag.
  always_ff @(posedge clk) begin
    case (state)
      lufnp_pkg::ST_IDLE: begin
        i         <= '0;
        sat       <= 1'b0;
        rd_inside <= cmd_inside;
      end
      lufnp_pkg::ST_PIV_LAT: begin
        piv <= rdata;
        r   <= i + 1'b1;
      end
      lufnp_pkg::ST_DIV_RUN: begin
        if (div_res.done) begin
          sat <= sat | div_res.sat;
          r   <= (NW'(r) == n_last) ? i + 1'b1 : r + 1'b1;
        end
      end
      lufnp_pkg::ST_L_LAT: begin
        l_reg <= rdata;
        c     <= i + 1'b1;
      end
      lufnp_pkg::ST_A_RD: begin
        u_reg <= rdata;
      end
      lufnp_pkg::ST_MUL: begin
        a_reg <= rdata;
        prod  <= l_reg * u_reg;
      end
      lufnp_pkg::ST_RND: begin
        prm <= prod[2*W-1] ? -$signed({1'b0, mmag}) : $signed({1'b0, mmag});
      end
      lufnp_pkg::ST_WB: begin
        sat <= sat | wb_sat;
        if (NW'(c) != n_last) begin
          c <= c + 1'b1;
        end else if (NW'(r) != n_last) begin
          r <= r + 1'b1;
        end else begin
          i <= i + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration register and status of the last factorization.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= lufnp_pkg::SIZE_W'(16);
      last_status <= lufnp_pkg::STAT_OK;
    end else begin
      if (cfg_we) begin
        matrix_size <= cfg_wdata;
      end
      if (fin) begin
        last_status <= load_status;
      end
    end
  end

  // Response register; a loaded word waits until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data   <= load_data;
      out_status <= load_status;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign rsp.status = out_status;

  lufnp_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  lufnp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (rdata),
    .d     (piv),
    .res   (div_res)
  );

  // A new command never overwrites a response that has not been taken.
  `LUFNP_CHECK(a_no_rsp_overwrite, clk, rst, cmd_fire |-> (!out_valid || rsp.ready))
  // The divider is only started when idle.
  `LUFNP_CHECK(a_div_start_idle, clk, rst, div_start |-> !div_res.busy)
  // Pivot step stays below the last row while factorizing.
  `LUFNP_NEVER(a_step_range, clk, rst, (state == lufnp_pkg::ST_PIV_RD) && (NW'(i) >= n_last))

endmodule
